[hdl/tga_rle_pkg.sv]
// Shared constants and types for the TGA run-length packet decoder.
package tga_rle_pkg;

  localparam logic [7:0] HDR_RUN_MASK   = 8'h80;
  localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;

  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned REPEAT_W = 8;
  localparam int unsigned CHAN_W = 3;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [CHAN_W-1:0]  CHAN_RESET  = 3'd3;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_PIXEL_TOTAL   = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0]  pixel_value;
    logic [REPEAT_W-1:0] repeat_count;
    logic                image_done;
    logic                overrun_error;
  } result_t;

endpackage

[hdl/tga_rle_packet_decoder.sv]
// TGA run-length packet decoder: header and pixel byte parsing, image count, result register.
// A byte that completes a pixel shows its result on the registered outputs in the cycle after its transfer.
// Throughput: one byte per cycle; the only stall comes from a held result that is not yet taken.
// Header and non-final channel bytes update the packet state and give no result.
// Reset (rst, synchronous): channel_count = 3, pixel_total = 1, decoder waits for a header,
// image pixel count zero, result register empty.
module tga_rle_packet_decoder
  import tga_rle_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                data_valid,
  output logic                data_stall,
  input  logic [7:0]          data_byte,
  output logic                pixel_valid,
  input  logic                pixel_stall,
  output logic [PIXEL_W-1:0]  pixel_value,
  output logic [REPEAT_W-1:0] repeat_count,
  output logic                image_done,
  output logic                overrun_error
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_RUN    = 2'd1;
  localparam logic [1:0] PH_RAW    = 2'd2;

  localparam int unsigned GATHER_W = 8 * MAX_CHANNELS;
  localparam logic [CHAN_W-1:0] MAX_CHAN = CHAN_W'(MAX_CHANNELS);

  logic [CHAN_W-1:0]   channel_count;
  logic [TOTAL_W-1:0]  pixel_total;

  logic [1:0]          phase, phase_next;
  logic [7:0]          packet_left, packet_left_next;
  logic [7:0]          run_length, run_length_next;
  logic [1:0]          byte_index, byte_index_next;
  logic [GATHER_W-1:0] gather, gather_next, gather_merged;
  logic [TOTAL_W-1:0]  image_left, image_left_next;
  logic                clipped, clipped_next;

  logic                take;
  logic                fire;
  result_t             result;
  logic [CHAN_W-1:0]   chans;
  logic                last_byte;
  logic [7:0]          hdr_count;
  logic [TOTAL_W-1:0]  image_start;
  logic [TOTAL_W-1:0]  run_sub;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PIXEL_TOTAL) ? pixel_total : 32'(channel_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHAN_RESET;
      pixel_total   <= TOTAL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_PIXEL_TOTAL) begin
        pixel_total <= pwdata;
      end else begin
        channel_count <= pwdata[CHAN_W-1:0];
      end
    end
  end

  assign chans = (channel_count == '0) ? CHAN_W'(1) :
                 ((channel_count > MAX_CHAN) ? MAX_CHAN : channel_count);
  assign last_byte = ({1'b0, byte_index} + CHAN_W'(1)) >= chans;

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    assign gather_merged[8*i +: 8] =
      gather[8*i +: 8] | ((byte_index == 2'(i)) ? data_byte : 8'h00);
  end

  assign take = data_valid && !data_stall;
  assign data_stall = pixel_valid && pixel_stall;

  always_comb begin
    phase_next       = phase;
    packet_left_next = packet_left;
    run_length_next  = run_length;
    byte_index_next  = byte_index;
    gather_next      = gather;
    image_left_next  = image_left;
    clipped_next     = clipped;
    fire             = 1'b0;
    result           = '0;
    hdr_count        = 8'({1'b0, data_byte & HDR_COUNT_MASK} + 9'd1);
    image_start      = image_left;
    run_sub          = '0;
    if (phase != PH_RUN && phase != PH_RAW) begin
      if (image_left == '0) begin
        image_start = (pixel_total == '0) ? TOTAL_W'(1) : pixel_total;
      end
      image_left_next = image_start;
      clipped_next    = 1'b0;
      if (TOTAL_W'(hdr_count) > image_start) begin
        hdr_count    = image_start[7:0];
        clipped_next = 1'b1;
      end
      packet_left_next = hdr_count;
      run_length_next  = hdr_count;
      byte_index_next  = '0;
      gather_next      = '0;
      phase_next       = ((data_byte & HDR_RUN_MASK) != 8'h00) ? PH_RUN : PH_RAW;
    end else if (!last_byte) begin
      byte_index_next = byte_index + 2'd1;
      gather_next     = gather_merged;
    end else begin
      fire = 1'b1;
      if (phase == PH_RUN) begin
        run_sub = (TOTAL_W'(run_length) <= image_left) ? TOTAL_W'(run_length) : image_left;
        image_left_next     = image_left - run_sub;
        packet_left_next    = '0;
        phase_next          = PH_HEADER;
        result.repeat_count = run_length;
      end else begin
        if (image_left != '0) image_left_next = image_left - TOTAL_W'(1);
        if (packet_left != '0) packet_left_next = packet_left - 8'd1;
        if (packet_left_next == '0 || image_left_next == '0) begin
          packet_left_next = '0;
          phase_next       = PH_HEADER;
        end
        result.repeat_count = 8'd1;
      end
      result.pixel_value   = PIXEL_W'(gather_merged);
      result.image_done    = (image_left_next == '0);
      result.overrun_error = clipped;
      byte_index_next      = '0;
      gather_next          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      packet_left <= '0;
      run_length  <= '0;
      byte_index  <= '0;
      gather      <= '0;
      image_left  <= '0;
      clipped     <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      packet_left <= packet_left_next;
      run_length  <= run_length_next;
      byte_index  <= byte_index_next;
      gather      <= gather_next;
      image_left  <= image_left_next;
      clipped     <= clipped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (take && fire) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire) begin
      pixel_value   <= result.pixel_value;
      repeat_count  <= result.repeat_count;
      image_done    <= result.image_done;
      overrun_error <= result.overrun_error;
    end
  end

  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (repeat_count != 8'd0 && repeat_count <= 8'd128))
    else $error("repeat count out of range");

  a_image_open: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RUN || phase == PH_RAW) |-> (image_left != '0))
    else $error("pixel phase with no image pixels left");

  a_raw_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RAW) |-> (packet_left != 8'd0))
    else $error("raw phase with empty packet");

  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    (take && fire && result.image_done) |=> (phase == PH_HEADER && image_left == '0))
    else $error("image done but decoder not back at header");

  a_header_no_result: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_HEADER) |=> ($stable(pixel_value) || !pixel_valid))
    else $error("header byte produced a result");

endmodule
